// File: hdl/crlt_pkg.sv
// ----------------------------------------------------------------------------
// crlt_pkg
// Shared types and constants of the child and route learning table: payload
// words, status codes and the microcode control word.
// ----------------------------------------------------------------------------
package crlt_pkg;

  localparam int CHILD_DEPTH = 16;
  localparam int ROUTE_DEPTH = 256;

  localparam int CIDX_W = (CHILD_DEPTH > 1) ? $clog2(CHILD_DEPTH) : 1;
  localparam int RIDX_W = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
  localparam int CCNT_W = $clog2(CHILD_DEPTH + 1);
  localparam int RCNT_W = $clog2(ROUTE_DEPTH + 1);
  localparam int IDX_W  = (CCNT_W > RCNT_W) ? CCNT_W : RCNT_W;

  localparam int PC_W = 5;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] sender_addr;
    logic [7:0]  origin_id;
    logic [7:0]  dest_id;
  } item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] next_hop;
  } result_t;

  typedef enum logic [3:0] {
    ST_ADDED       = 4'd0,
    ST_ROUTE_FULL1 = 4'd1,
    ST_CHILD_FULL  = 4'd2,
    ST_LEARNED     = 4'd3,
    ST_KNOWN       = 4'd4,
    ST_IS_SENDER   = 4'd5,
    ST_ROUTE_FULL  = 4'd6,
    ST_FOUND       = 4'd7,
    ST_NOT_FOUND   = 4'd8
  } status_t;

  // Jump conditions tested by a control word.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE,
    C_LOOKUP,
    C_CEND,
    C_CNOMATCH,
    C_REND,
    C_RNOMATCH,
    C_CFULL,
    C_RFULL,
    C_SAME
  } cond_t;

  typedef enum logic [1:0] {
    KEY_HOLD,
    KEY_SENDER,
    KEY_ORIGIN,
    KEY_DEST
  } key_sel_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC
  } idx_op_t;

  typedef struct packed {
    cond_t    cond;
    pc_t      target;
    key_sel_t key_sel;
    idx_op_t  idx_op;
    logic     rd;
    logic     child_wr;
    logic     route_wr;
    logic     done;
    status_t  status;
  } ucode_t;

  typedef struct packed {
    logic lookup;
    logic cend;
    logic cmatch;
    logic rend;
    logic rmatch;
    logic cfull;
    logic rfull;
    logic same;
  } flags_t;

  localparam ucode_t UC_NOP = '{
    cond:     C_NEVER,
    target:   '0,
    key_sel:  KEY_HOLD,
    idx_op:   IDX_HOLD,
    rd:       1'b0,
    child_wr: 1'b0,
    route_wr: 1'b0,
    done:     1'b0,
    status:   ST_ADDED
  };

endpackage

// File: hdl/child_route_learning_table.sv
// ----------------------------------------------------------------------------
// child_route_learning_table
// Gateway forwarding table: learns direct children and routes through them
// and answers next-hop lookups, under control of a microcoded sequencer.
// ----------------------------------------------------------------------------
// One word is in work at a time; the next is taken in the cycle after the result
// is written, and a stalled result holds the sequencer. Each word is handled by a
// linear scan over the single-port stores.
// Reset clears both fill counts, emptying the stores; a word is taken in the first cycle after it.
module child_route_learning_table
  import crlt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic        idle;
  logic        go;
  logic        out_blocked;
  ucode_t      uc;
  flags_t      flags;
  logic [15:0] hop_rd;

  assign item_stall  = !idle;
  assign go          = item_valid && idle;
  assign out_blocked = result_valid && result_stall;

  crlt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .flags       (flags),
    .out_blocked (out_blocked),
    .uc          (uc),
    .idle        (idle)
  );

  crlt_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .load   (go),
    .item   (item),
    .uc     (uc),
    .flags  (flags),
    .hop_rd (hop_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (uc.done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.done) begin
      result.status   <= uc.status;
      result.next_hop <= (uc.status == ST_FOUND) ? hop_rd : 16'd0;
    end
  end

endmodule

// File: hdl/crlt_dpath.sv
// ----------------------------------------------------------------------------
// crlt_dpath
// Datapath of the table: input word registers, search key and index, the
// child and route stores with registered reads, and the fill counts.
// ----------------------------------------------------------------------------
module crlt_dpath
  import crlt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  item_t       item,
  input  ucode_t      uc,
  output flags_t      flags,
  output logic [15:0] hop_rd
);

  logic              cmd;
  logic [15:0]       sender;
  logic [15:0]       origin;
  logic [15:0]       dest;
  logic [15:0]       key;
  logic [IDX_W-1:0]  idx;
  logic [CCNT_W-1:0] child_count;
  logic [RCNT_W-1:0] route_count;
  logic [15:0]       child_rd;
  logic [15:0]       rdest_rd;
  logic [15:0]       rhop_rd;

  logic [15:0] child_mem [CHILD_DEPTH];
  logic [15:0] rdest_mem [ROUTE_DEPTH];
  logic [15:0] rhop_mem  [ROUTE_DEPTH];

  always_ff @(posedge clk) begin
    if (load) begin
      cmd    <= item.cmd;
      sender <= item.sender_addr;
      origin <= {8'd0, item.origin_id};
      dest   <= {8'd0, item.dest_id};
    end
    case (uc.key_sel)
      KEY_SENDER: key <= sender;
      KEY_ORIGIN: key <= origin;
      KEY_DEST:   key <= dest;
      default:    key <= key;
    endcase
    case (uc.idx_op)
      IDX_CLR: idx <= '0;
      IDX_INC: idx <= idx + IDX_W'(1);
      default: idx <= idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      child_count <= '0;
      route_count <= '0;
    end else begin
      if (uc.child_wr) child_count <= child_count + CCNT_W'(1);
      if (uc.route_wr) route_count <= route_count + RCNT_W'(1);
    end
  end

  // Writes always go to the next free slot; the sequencer checks fullness first.
  always_ff @(posedge clk) begin
    if (uc.child_wr) child_mem[child_count[CIDX_W-1:0]] <= key;
    if (uc.rd) child_rd <= child_mem[idx[CIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (uc.route_wr) begin
      rdest_mem[route_count[RIDX_W-1:0]] <= key;
      rhop_mem[route_count[RIDX_W-1:0]]  <= sender;
    end
    if (uc.rd) begin
      rdest_rd <= rdest_mem[idx[RIDX_W-1:0]];
      rhop_rd  <= rhop_mem[idx[RIDX_W-1:0]];
    end
  end

  always_comb begin
    flags.lookup = cmd;
    flags.cend   = idx >= IDX_W'(child_count);
    flags.cmatch = child_rd == key;
    flags.rend   = idx >= IDX_W'(route_count);
    flags.rmatch = rdest_rd == key;
    flags.cfull  = child_count >= CCNT_W'(CHILD_DEPTH);
    flags.rfull  = route_count >= RCNT_W'(ROUTE_DEPTH);
    flags.same   = origin == sender;
  end

  assign hop_rd = rhop_rd;

endmodule

// File: hdl/crlt_ctrl.sv
// ----------------------------------------------------------------------------
// crlt_ctrl
// Microcoded sequencer: a step counter walks a small control program held in
// a read-only table, with one conditional jump per step.
// ----------------------------------------------------------------------------
module crlt_ctrl
  import crlt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   go,
  input  flags_t flags,
  input  logic   out_blocked,
  output ucode_t uc,
  output logic   idle
);

  localparam pc_t P_IDLE      = PC_W'(0);
  localparam pc_t P_START     = PC_W'(1);
  localparam pc_t P_CL_RD     = PC_W'(2);
  localparam pc_t P_CL_CMP    = PC_W'(3);
  localparam pc_t P_KNOWN     = PC_W'(4);
  localparam pc_t P_RT_RD     = PC_W'(5);
  localparam pc_t P_RT_CMP    = PC_W'(6);
  localparam pc_t P_RT_KNOWN  = PC_W'(7);
  localparam pc_t P_LRN       = PC_W'(8);
  localparam pc_t P_LRN_ADD   = PC_W'(9);
  localparam pc_t P_LRN_FULL  = PC_W'(10);
  localparam pc_t P_SAME      = PC_W'(11);
  localparam pc_t P_NEW       = PC_W'(12);
  localparam pc_t P_NEW_WR    = PC_W'(13);
  localparam pc_t P_NEW_RT    = PC_W'(14);
  localparam pc_t P_NEW_RFULL = PC_W'(15);
  localparam pc_t P_NEW_CFULL = PC_W'(16);
  localparam pc_t P_LOOKUP    = PC_W'(17);
  localparam pc_t P_LK_RD     = PC_W'(18);
  localparam pc_t P_LK_CMP    = PC_W'(19);
  localparam pc_t P_LK_FOUND  = PC_W'(20);
  localparam pc_t P_LK_NONE   = PC_W'(21);

  function automatic ucode_t mk(cond_t c, pc_t t, key_sel_t k, idx_op_t i,
                                logic rd, logic cw, logic rw, logic dn,
                                status_t st);
    ucode_t w;
    w.cond     = c;
    w.target   = t;
    w.key_sel  = k;
    w.idx_op   = i;
    w.rd       = rd;
    w.child_wr = cw;
    w.route_wr = rw;
    w.done     = dn;
    w.status   = st;
    return w;
  endfunction

  pc_t    pc;
  pc_t    pc_next;
  ucode_t rom_word;
  logic   take;
  logic   hold;

  // The control program. A compare step loops back on a miss and falls
  // through on a hit; a done step hands the result over and returns to idle.
  always_comb begin
    case (pc)
      P_IDLE:      rom_word = mk(C_IDLE, P_IDLE, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b0, 1'b0, 1'b0, ST_ADDED);
      P_START:     rom_word = mk(C_LOOKUP, P_LOOKUP, KEY_SENDER, IDX_CLR,
                                 1'b0, 1'b0, 1'b0, 1'b0, ST_ADDED);
      P_CL_RD:     rom_word = mk(C_CEND, P_NEW, KEY_HOLD, IDX_HOLD,
                                 1'b1, 1'b0, 1'b0, 1'b0, ST_ADDED);
      P_CL_CMP:    rom_word = mk(C_CNOMATCH, P_CL_RD, KEY_HOLD, IDX_INC,
                                 1'b0, 1'b0, 1'b0, 1'b0, ST_ADDED);
      P_KNOWN:     rom_word = mk(C_SAME, P_SAME, KEY_ORIGIN, IDX_CLR,
                                 1'b0, 1'b0, 1'b0, 1'b0, ST_ADDED);
      P_RT_RD:     rom_word = mk(C_REND, P_LRN, KEY_HOLD, IDX_HOLD,
                                 1'b1, 1'b0, 1'b0, 1'b0, ST_ADDED);
      P_RT_CMP:    rom_word = mk(C_RNOMATCH, P_RT_RD, KEY_HOLD, IDX_INC,
                                 1'b0, 1'b0, 1'b0, 1'b0, ST_ADDED);
      P_RT_KNOWN:  rom_word = mk(C_ALWAYS, P_IDLE, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b0, 1'b0, 1'b1, ST_KNOWN);
      P_LRN:       rom_word = mk(C_RFULL, P_LRN_FULL, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b0, 1'b0, 1'b0, ST_ADDED);
      P_LRN_ADD:   rom_word = mk(C_ALWAYS, P_IDLE, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b0, 1'b1, 1'b1, ST_LEARNED);
      P_LRN_FULL:  rom_word = mk(C_ALWAYS, P_IDLE, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b0, 1'b0, 1'b1, ST_ROUTE_FULL);
      P_SAME:      rom_word = mk(C_ALWAYS, P_IDLE, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b0, 1'b0, 1'b1, ST_IS_SENDER);
      P_NEW:       rom_word = mk(C_CFULL, P_NEW_CFULL, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b0, 1'b0, 1'b0, ST_ADDED);
      P_NEW_WR:    rom_word = mk(C_RFULL, P_NEW_RFULL, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b1, 1'b0, 1'b0, ST_ADDED);
      P_NEW_RT:    rom_word = mk(C_ALWAYS, P_IDLE, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b0, 1'b1, 1'b1, ST_ADDED);
      P_NEW_RFULL: rom_word = mk(C_ALWAYS, P_IDLE, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b0, 1'b0, 1'b1, ST_ROUTE_FULL1);
      P_NEW_CFULL: rom_word = mk(C_ALWAYS, P_IDLE, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b0, 1'b0, 1'b1, ST_CHILD_FULL);
      P_LOOKUP:    rom_word = mk(C_NEVER, P_IDLE, KEY_DEST, IDX_HOLD,
                                 1'b0, 1'b0, 1'b0, 1'b0, ST_ADDED);
      P_LK_RD:     rom_word = mk(C_REND, P_LK_NONE, KEY_HOLD, IDX_HOLD,
                                 1'b1, 1'b0, 1'b0, 1'b0, ST_ADDED);
      P_LK_CMP:    rom_word = mk(C_RNOMATCH, P_LK_RD, KEY_HOLD, IDX_INC,
                                 1'b0, 1'b0, 1'b0, 1'b0, ST_ADDED);
      P_LK_FOUND:  rom_word = mk(C_ALWAYS, P_IDLE, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b0, 1'b0, 1'b1, ST_FOUND);
      P_LK_NONE:   rom_word = mk(C_ALWAYS, P_IDLE, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b0, 1'b0, 1'b1, ST_NOT_FOUND);
      default:     rom_word = mk(C_ALWAYS, P_IDLE, KEY_HOLD, IDX_HOLD,
                                 1'b0, 1'b0, 1'b0, 1'b0, ST_ADDED);
    endcase
  end

  always_comb begin
    case (rom_word.cond)
      C_ALWAYS:   take = 1'b1;
      C_IDLE:     take = !go;
      C_LOOKUP:   take = flags.lookup;
      C_CEND:     take = flags.cend;
      C_CNOMATCH: take = !flags.cmatch;
      C_REND:     take = flags.rend;
      C_RNOMATCH: take = !flags.rmatch;
      C_CFULL:    take = flags.cfull;
      C_RFULL:    take = flags.rfull;
      C_SAME:     take = flags.same;
      default:    take = 1'b0;
    endcase
  end

  // A done step waits, with all its effects held back, while the output
  // register still has a word that the far side has not taken.
  assign hold    = rom_word.done && out_blocked;
  assign uc      = hold ? UC_NOP : rom_word;
  assign pc_next = hold ? pc : (take ? rom_word.target : pc + PC_W'(1));
  assign idle    = pc == P_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= P_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: verif/tb_child_route_learning_table.sv
// ----------------------------------------------------------------------------
// tb_child_route_learning_table
// Self-checking bench for the gateway forwarding table. A short table of
// directed words covers the first child, self routes, known routes, an origin
// equal to its sender and duplicate destinations. Random traffic then grows the
// child and route stores until both overflow. Every result word is compared
// with a local model of the two stores, or with the answer that a typed row carries.
// ----------------------------------------------------------------------------
module tb_child_route_learning_table;
  import crlt_pkg::*;

  localparam logic CMD_LEARN  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int DRAIN_CYCLES = 2 * CHILD_DEPTH + 2 * ROUTE_DEPTH + 48;
  localparam int HOLD_CYCLES  = 2500;
  localparam int POOL_SIZE    = 24;

  typedef struct packed {
    logic        typed_row;
    status_t     st;
    logic [15:0] hop;
    item_t       w;
  } plan_row_t;

  // Rows with typed_row set carry their answer; the others rely on the model.
  localparam int PLAN_LEN = 21;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{1'b1, ST_NOT_FOUND, 16'h0000, '{CMD_LOOKUP, 16'hA5A5, 8'h5A, 8'h00}},
    '{1'b1, ST_ADDED,     16'h0000, '{CMD_LEARN,  16'hFFFF, 8'h00, 8'hC3}},
    '{1'b1, ST_LEARNED,   16'h0000, '{CMD_LEARN,  16'hFFFF, 8'hFF, 8'h00}},
    '{1'b1, ST_KNOWN,     16'h0000, '{CMD_LEARN,  16'hFFFF, 8'hFF, 8'h00}},
    '{1'b1, ST_ADDED,     16'h0000, '{CMD_LEARN,  16'h0005, 8'h05, 8'h00}},
    '{1'b1, ST_IS_SENDER, 16'h0000, '{CMD_LEARN,  16'h0005, 8'h05, 8'h00}},
    '{1'b0, ST_ADDED,     16'h0000, '{CMD_LEARN,  16'hFFFF, 8'h05, 8'h7E}},
    '{1'b0, ST_ADDED,     16'h0000, '{CMD_LOOKUP, 16'h0000, 8'h00, 8'h05}},
    '{1'b0, ST_ADDED,     16'h0000, '{CMD_LOOKUP, 16'h1234, 8'h81, 8'hFF}},
    '{1'b1, ST_ADDED,     16'h0000, '{CMD_LEARN,  16'h0000, 8'h80, 8'hFF}},
    '{1'b0, ST_ADDED,     16'h0000, '{CMD_LOOKUP, 16'hFFFF, 8'hFF, 8'h00}},
    '{1'b0, ST_ADDED,     16'h0000, '{CMD_LEARN,  16'h0000, 8'h07, 8'h00}},
    '{1'b0, ST_ADDED,     16'h0000, '{CMD_LEARN,  16'h0007, 8'h07, 8'h00}},
    '{1'b0, ST_ADDED,     16'h0000, '{CMD_LOOKUP, 16'h0000, 8'h00, 8'h07}},
    '{1'b0, ST_ADDED,     16'h0000, '{CMD_LEARN,  16'h0007, 8'h07, 8'hFF}},
    '{1'b0, ST_ADDED,     16'h0000, '{CMD_LEARN,  16'h0007, 8'h00, 8'h00}},
    '{1'b1, ST_NOT_FOUND, 16'h0000, '{CMD_LOOKUP, 16'h0000, 8'h00, 8'h80}},
    '{1'b0, ST_ADDED,     16'h0000, '{CMD_LEARN,  16'h0005, 8'h80, 8'h00}},
    '{1'b0, ST_ADDED,     16'h0000, '{CMD_LOOKUP, 16'h0000, 8'h00, 8'h80}},
    '{1'b0, ST_ADDED,     16'h0000, '{CMD_LEARN,  16'hFF00, 8'h00, 8'h00}},
    '{1'b0, ST_ADDED,     16'h0000, '{CMD_LOOKUP, 16'hFFFF, 8'hFF, 8'h01}}
  };

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  // Local copy of the forwarding table.
  logic [15:0] kid_addr [CHILD_DEPTH];
  int unsigned kid_cnt;
  logic [15:0] rt_dest [ROUTE_DEPTH];
  logic [15:0] rt_hop [ROUTE_DEPTH];
  int unsigned rt_cnt;

  result_t     pending_answers [$];
  logic [15:0] kin [POOL_SIZE];
  int unsigned words_taken;
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          no_gaps;
  logic        long_hold;

  child_route_learning_table i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int route_slot(input logic [15:0] d);
    int slot;
    slot = -1;
    for (int i = rt_cnt - 1; i >= 0; i--) begin
      if (rt_dest[i] == d) slot = i;
    end
    return slot;
  endfunction

  function automatic bit route_append(input logic [15:0] d, input logic [15:0] h);
    bit room;
    room = rt_cnt < ROUTE_DEPTH;
    if (room) begin
      rt_dest[rt_cnt] = d;
      rt_hop[rt_cnt]  = h;
      rt_cnt++;
    end
    return room;
  endfunction

  // Applies one word to the local table and returns the answer it should give.
  function automatic result_t table_answer(input item_t w);
    result_t     r;
    logic [15:0] org;
    int          slot;
    bit          known;
    r.status   = ST_NOT_FOUND;
    r.next_hop = '0;
    org        = {8'h00, w.origin_id};
    if (w.cmd == CMD_LOOKUP) begin
      slot = route_slot({8'h00, w.dest_id});
      if (slot >= 0) begin
        r.status   = ST_FOUND;
        r.next_hop = rt_hop[slot];
      end
    end else begin
      known = 1'b0;
      for (int i = 0; i < kid_cnt; i++) begin
        if (kid_addr[i] == w.sender_addr) known = 1'b1;
      end
      if (!known) begin
        if (kid_cnt >= CHILD_DEPTH) begin
          r.status = ST_CHILD_FULL;
        end else begin
          kid_addr[kid_cnt] = w.sender_addr;
          kid_cnt++;
          // A new child's self route goes in without a duplicate check.
          r.status = route_append(w.sender_addr, w.sender_addr) ? ST_ADDED : ST_ROUTE_FULL1;
        end
      end else if (org == w.sender_addr) begin
        r.status = ST_IS_SENDER;
      end else if (route_slot(org) >= 0) begin
        r.status = ST_KNOWN;
      end else begin
        r.status = route_append(org, w.sender_addr) ? ST_LEARNED : ST_ROUTE_FULL;
      end
    end
    return r;
  endfunction

  function automatic item_t learn_word(input logic [15:0] s, input logic [7:0] o);
    item_t w;
    w.cmd         = CMD_LEARN;
    w.sender_addr = s;
    w.origin_id   = o;
    w.dest_id     = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic item_t lookup_word(input logic [7:0] d);
    item_t w;
    w.cmd         = CMD_LOOKUP;
    w.sender_addr = 16'($urandom_range(0, 65535));
    w.origin_id   = 8'($urandom_range(0, 255));
    w.dest_id     = d;
    return w;
  endfunction

  task automatic report_fault(input string what, input int unsigned want,
                              input int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  task automatic offer_word(input item_t w, input bit typed_row, input result_t typed_res);
    int      gap;
    result_t r;
    if (words_taken % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    r = table_answer(w);
    pending_answers.push_back(typed_row ? typed_res : r);
    words_taken++;
  endtask

  // One random word: a learn from a child of the first pool_top+1 senders,
  // or a lookup of any destination.
  task automatic offer_mixed(input int pool_top);
    logic [15:0] s;
    logic [7:0]  o;
    s = kin[$urandom_range(0, pool_top)];
    o = ($urandom_range(0, 5) == 0) ? s[7:0] : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 55) offer_word(learn_word(s, o), 1'b0, '0);
    else offer_word(lookup_word(8'($urandom_range(0, 255))), 1'b0, '0);
  endtask

  // Result side: random stalls after each word, plus the long hold-off.
  initial begin
    int      stall_left;
    result_t want;
    stall_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid === 1'b1 && !result_stall) begin
        if (pending_answers.size() == 0) begin
          report_fault("unexpected word, status", 0, result.status);
        end else begin
          want = pending_answers.pop_front();
          if (result.status !== want.status) report_fault("status", want.status, result.status);
          if (result.next_hop !== want.next_hop) begin
            report_fault("next_hop", want.next_hop, result.next_hop);
          end
        end
        stall_left = no_gaps ? 0 : $urandom_range(0, 8);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      result_stall <= long_hold || (stall_left > 0);
    end
  end

  // Holds the result side off twice for a long stretch so the block backs up.
  initial begin
    int unsigned hold_at [2];
    hold_at[0] = 80;
    hold_at[1] = 1400;
    long_hold <= 1'b0;
    for (int k = 0; k < 2; k++) begin
      wait (words_taken >= hold_at[k]);
      @(posedge clk);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      long_hold <= 1'b0;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_child_route_learning_table: errors");
    $finish;
  end

  initial begin
    logic [15:0] cand;
    bit          dup;
    result_t     typed_res;
    rst         <= 1'b1;
    item_valid  <= 1'b0;
    item        <= '0;
    kid_cnt     = 0;
    rt_cnt      = 0;
    words_taken = 0;
    mismatches  = 0;
    no_gaps     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      typed_res.status   = PLAN[i].st;
      typed_res.next_hop = PLAN[i].hop;
      offer_word(PLAN[i].w, PLAN[i].typed_row, typed_res);
    end

    // Sender pool: the children of the directed part, then distinct new ones.
    // A few new ones have a zero high byte so that they collide with origins.
    kin[0] = 16'hFFFF;
    kin[1] = 16'h0005;
    kin[2] = 16'h0000;
    kin[3] = 16'h0007;
    kin[4] = 16'hFF00;
    for (int i = 5; i < POOL_SIZE; i++) begin
      do begin
        cand = 16'($urandom_range(0, 65535));
        if (i == 5 || i == 10) cand[15:8] = 8'h00;
        dup = 1'b0;
        for (int j = 0; j < i; j++) begin
          if (kin[j] == cand) dup = 1'b1;
        end
      end while (dup);
      kin[i] = cand;
    end

    // Few children, random origins: the route store grows but keeps room.
    repeat (500) offer_mixed(7);
    // Sweep every origin through known children until the route store is full.
    for (int o = 0; o < 256; o++) begin
      offer_word(learn_word(kin[$urandom_range(0, 7)], 8'(o)), 1'b0, '0);
      offer_word(lookup_word(8'($urandom_range(0, 255))), 1'b0, '0);
    end
    // New child while the route store is full.
    offer_word(learn_word(kin[8], 8'($urandom_range(0, 255))), 1'b0, '0);
    // Wider pool: the child store overflows.
    repeat (820) offer_mixed(POOL_SIZE - 1);
    item_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("tb_child_route_learning_table: clean");
    end else begin
      $display("tb_child_route_learning_table: errors");
    end
    $finish;
  end

endmodule
